/* sv/dsf_pkg.sv */
// Shared definitions for the duplicate sequence filter: history geometry,
// verdict and register codes, configuration struct and controller states.
// No dependencies; every other file but dsf_hist_ram imports this package.
package dsf_pkg;

  // History ring geometry.
  localparam int HISTORY_DEPTH = 32;
  localparam int HIST_AW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int SEQ_W         = 16;

  // Shortest datagram that is screened further.
  localparam logic [15:0] MIN_LENGTH = 16'd21;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_SESSION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_COMMAND    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_ID_COMMAND = 2'd2;

  localparam logic [31:0] OWN_SESSION_RESET    = 32'd0;
  localparam logic [15:0] ACK_COMMAND_RESET    = 16'd10;
  localparam logic [15:0] NEW_ID_COMMAND_RESET = 16'd70;

  // Verdict codes.
  typedef enum logic [2:0] {
    V_SHORT         = 3'd0,
    V_BAD_SESSION   = 3'd1,
    V_DUPLICATE     = 3'd2,
    V_DELIVER_ACK   = 3'd3,
    V_DELIVER_PLAIN = 3'd4
  } verdict_t;

  // Configuration as seen by the controller.
  typedef struct packed {
    logic [31:0] own_session;
    logic [15:0] ack_command;
    logic [15:0] new_id_command;
  } cfg_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

/* sv/dsf_hist_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the sequence history ring; no package dependencies.
module dsf_hist_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/dsf_cfg_regs.sv */
// Configuration register file of the duplicate sequence filter.
// Depends on dsf_pkg for register indexes, reset values and cfg_t.
module dsf_cfg_regs
  import dsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 cfg
);

  // Writes are always taken; indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_session    <= OWN_SESSION_RESET;
      cfg.ack_command    <= ACK_COMMAND_RESET;
      cfg.new_id_command <= NEW_ID_COMMAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_SESSION:    cfg.own_session    <= cfg_data;
        REG_ACK_COMMAND:    cfg.ack_command    <= cfg_data[15:0];
        REG_NEW_ID_COMMAND: cfg.new_id_command <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/dsf_ctrl.sv */
// Screening controller: header checks, history scan through the RAM read port,
// ring bookkeeping and the registered result word.
// Depends on dsf_pkg; drives the ports of dsf_hist_ram.
module dsf_ctrl
  import dsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        packet_length,
  input  logic [31:0]        session_id,
  input  logic [15:0]        command,
  input  logic [15:0]        seq_low,
  input  logic [15:0]        seq_high,
  output logic               done,
  output logic [2:0]         verdict,
  output logic               send_ack,
  output logic [31:0]        ack_id,
  output logic [31:0]        delivered_total,
  output logic               rd_en,
  output logic [HIST_AW-1:0] rd_addr,
  input  logic [SEQ_W-1:0]   rd_data,
  output logic               wr_en,
  output logic [HIST_AW-1:0] wr_addr,
  output logic [SEQ_W-1:0]   wr_data
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic               pend, pend_next;
  logic [15:0]        seq_q, seq_high_q;
  logic [HIST_AW-1:0] write_pointer;
  logic [CNT_W-1:0]   fill_count;
  logic [31:0]        recorded_count;

  logic               fin;
  verdict_t           fin_verdict;
  logic [15:0]        fin_low, fin_high;
  logic               fin_ack;
  logic               record;

  assign busy = (state != ST_IDLE);

  // Next state, scan reads and the verdict of a finishing word.
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    pend_next   = pend;
    fin         = 1'b0;
    fin_verdict = V_SHORT;
    fin_low     = seq_q;
    fin_high    = seq_high_q;
    rd_en       = 1'b0;
    rd_addr     = idx[HIST_AW-1:0];
    case (state)
      ST_IDLE: begin
        fin_low  = seq_low;
        fin_high = seq_high;
        if (start) begin
          if (packet_length < MIN_LENGTH) begin
            fin         = 1'b1;
            fin_verdict = V_SHORT;
          end else if (session_id != cfg.own_session) begin
            fin         = 1'b1;
            fin_verdict = V_BAD_SESSION;
          end else if (command == cfg.ack_command) begin
            fin         = 1'b1;
            fin_verdict = V_DELIVER_PLAIN;
          end else if (command == cfg.new_id_command || seq_low == 16'd0) begin
            fin         = 1'b1;
            fin_verdict = V_DELIVER_ACK;
          end else begin
            state_next = ST_SCAN;
            idx_next   = '0;
            pend_next  = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // Compare the entry read last cycle while the next read is issued.
        if (pend && rd_data == seq_q) begin
          fin         = 1'b1;
          fin_verdict = V_DUPLICATE;
          state_next  = ST_IDLE;
        end else if (idx == fill_count) begin
          fin         = 1'b1;
          fin_verdict = V_DELIVER_ACK;
          state_next  = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          idx_next  = idx + CNT_W'(1);
          pend_next = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign fin_ack = (fin_verdict == V_DUPLICATE) || (fin_verdict == V_DELIVER_ACK);
  assign record  = fin && (fin_verdict == V_DELIVER_ACK);
  assign wr_en   = record;
  assign wr_addr = write_pointer;
  assign wr_data = fin_low;
  assign delivered_total = recorded_count;

  // Control state and ring bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      idx            <= '0;
      pend           <= 1'b0;
      write_pointer  <= '0;
      fill_count     <= '0;
      recorded_count <= '0;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      pend  <= pend_next;
      done  <= fin;
      if (record) begin
        recorded_count <= recorded_count + 32'd1;
        if (write_pointer == HIST_AW'(HISTORY_DEPTH - 1)) begin
          write_pointer <= '0;
        end else begin
          write_pointer <= write_pointer + HIST_AW'(1);
        end
        if (fill_count < CNT_W'(HISTORY_DEPTH)) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
    end
  end

  // Captured sequence numbers and the result word.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      seq_q      <= seq_low;
      seq_high_q <= seq_high;
    end
    if (fin) begin
      verdict  <= fin_verdict;
      send_ack <= fin_ack;
      ack_id   <= fin_ack ? {fin_high, fin_low} : 32'd0;
    end
  end

  // A result word is only shown once the controller is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result shown while a scan is in progress");

  // The ring never claims more valid entries than it has.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  // The scan never reads past the written entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx <= fill_count)
    else $error("scan index past fill count");

  // A recorded word advances the count by one; this checks that other words leave it alone.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    done && verdict != V_DELIVER_ACK |-> $stable(recorded_count))
    else $error("count changed for a word that was not recorded");

  // A duplicate is reported with an ack, and only after at least one entry was compared.
  a_dup_ack: assert property (@(posedge clk) disable iff (rst)
    done && verdict == V_DUPLICATE |-> send_ack && $past(pend))
    else $error("duplicate reported without a compared entry");

endmodule

/* sv/duplicate_sequence_filter.sv */
// Duplicate sequence filter: header screening with a history ring in RAM.
// Words decided by the header alone finish without leaving idle; a scanned word reads the
// valid ring entries in turn through the single RAM read port (a duplicate ends early).
// busy stays high during the scan and start is ignored then, so a new word is taken only
// while idle; done is a one-cycle strobe per result.
// Reset (rst, synchronous) empties the ring, clears the count and restores register defaults.
module duplicate_sequence_filter
  import dsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  logic [15:0]          packet_length,
  input  logic [31:0]          session_id,
  input  logic [15:0]          command,
  input  logic [15:0]          seq_low,
  input  logic [15:0]          seq_high,
  output logic                 done,
  output logic [2:0]           verdict,
  output logic                 send_ack,
  output logic [31:0]          ack_id,
  output logic [31:0]          delivered_total
);

  cfg_t               cfg;
  logic               rd_en, wr_en;
  logic [HIST_AW-1:0] rd_addr, wr_addr;
  logic [SEQ_W-1:0]   rd_data, wr_data;

  // Configuration registers.
  dsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequence history ring.
  dsf_hist_ram #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (SEQ_W),
    .AW    (HIST_AW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Screening controller.
  dsf_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .start           (start),
    .busy            (busy),
    .packet_length   (packet_length),
    .session_id      (session_id),
    .command         (command),
    .seq_low         (seq_low),
    .seq_high        (seq_high),
    .done            (done),
    .verdict         (verdict),
    .send_ack        (send_ack),
    .ack_id          (ack_id),
    .delivered_total (delivered_total),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data)
  );

endmodule
